>>> rtl/mpc_pkg.sv
`default_nettype none

package mpc_pkg;

	// Channel and pixel widths; pixels pack red in [7:0], green [15:8], blue [23:16].
	localparam int CHAN_W   = 8;
	localparam int NUM_CHAN = 3;
	localparam int PIXEL_W  = CHAN_W * NUM_CHAN;
	localparam int FIELD_W  = 9;
	localparam int WIDTH_W  = 13;

	// Register indexes of the configuration port.
	localparam logic CFG_MODE  = 1'b0;
	localparam logic CFG_WIDTH = 1'b1;

	typedef enum logic {
		MODE_ENCODE = 1'b0,
		MODE_DECODE = 1'b1
	} coder_mode_t;

	typedef logic [CHAN_W-1:0]  chan_t;
	typedef logic [PIXEL_W-1:0] pixel_t;
	typedef logic [FIELD_W-1:0] field_t;

	// Per-pixel control handed to the channel predictors.
	typedef struct packed {
		coder_mode_t mode;
		logic        raw;
	} pred_ctrl_t;

	// Median edge detector over left (a), upper (b) and upper-left (c).
	function automatic chan_t med(input chan_t a, input chan_t b, input chan_t c);
		chan_t lo;
		chan_t hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (c >= hi) begin
			return lo;
		end else if (c <= lo) begin
			return hi;
		end
		return CHAN_W'({1'b0, a} + {1'b0, b} - {1'b0, c});
	endfunction

endpackage

`default_nettype wire

>>> rtl/mpc_line_store.sv
`default_nettype none

module mpc_line_store
	import mpc_pkg::*;
#(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output pixel_t             rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire pixel_t        wr_data
);

	pixel_t mem [DEPTH];

	// Read returns the old contents on a same-address write; the caller forwards.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule

`default_nettype wire

>>> rtl/mpc_chan_predictor.sv
`default_nettype none

module mpc_chan_predictor
	import mpc_pkg::*;
(
	input  wire pred_ctrl_t ctrl,
	input  wire chan_t      left_chan,
	input  wire chan_t      upper_chan,
	input  wire chan_t      upper_left_chan,
	input  wire field_t     in_value,
	output field_t          out_value,
	output chan_t           pixel_chan
);

	chan_t pred;

	always_comb begin
		pred = ctrl.raw ? '0 : med(left_chan, upper_chan, upper_left_chan);
		unique case (ctrl.mode)
			MODE_ENCODE: begin
				pixel_chan = in_value[CHAN_W-1:0];
				out_value  = ctrl.raw ? {1'b0, pixel_chan}
				                      : FIELD_W'({1'b0, pixel_chan} - {1'b0, pred});
			end
			MODE_DECODE: begin
				pixel_chan = CHAN_W'(in_value[CHAN_W-1:0] + pred);
				out_value  = {1'b0, pixel_chan};
			end
			default: begin
				pixel_chan = '0;
				out_value  = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/med_predictive_pixel_coder.sv
`default_nettype none

// MED predictive pixel coder: median edge detector prediction on RGB pixels.
// Input channel: in_valid/in_ready with frame_start, in_red, in_green, in_blue.
//   In encode mode the fields are pixels 0..255; in decode mode residuals.
// Output channel: out_valid/out_ready with out_red, out_green, out_blue, is_raw.
//   Encode gives pixel minus prediction (raw pixel in first row or column);
//   decode gives pixel = prediction + residual mod 256.
// Configuration: cfg_valid/cfg_ready (always ready), cfg_index selects mode (0)
//   or image_width (1), cfg_data carries the value. Write only while idle.
// Pipeline: an accepted item passes through the stage 1 registers and then the
//   output register. Throughput: one item per cycle while out_ready does not
//   stall the output, set by the read-modify-write on the line store; a column
//   read in the accept cycle is forwarded when the item ahead writes the same
//   column in that cycle.
// Reset: mode encode, width 4096, position at the start of the first row,
//   left and upper-left neighbors zero. The line store is not cleared; entries
//   are written in row one before any predicted pixel reads them.
// Stall: the output register holds while out_ready is low; the stage ahead
//   keeps one more item, after which in_ready drops.
module med_predictive_pixel_coder
	import mpc_pkg::*;
#(
	parameter int MAX_WIDTH = 4096
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic         cfg_index,
	input  wire logic [12:0]  cfg_data,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic         frame_start,
	input  wire logic [8:0]   in_red,
	input  wire logic [8:0]   in_green,
	input  wire logic [8:0]   in_blue,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic signed [8:0] out_red,
	output logic signed [8:0] out_green,
	output logic signed [8:0] out_blue,
	output logic              is_raw
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int XW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;
	localparam int RESET_WIDTH = (4096 > MAX_WIDTH) ? MAX_WIDTH : 4096;
	localparam logic [CW-1:0] RESET_LAST = CW'(RESET_WIDTH - 1);
	localparam logic [CW-1:0] MAX_LAST   = CW'(MAX_WIDTH - 1);

	// Configuration: keep the last column index instead of the raw width.
	coder_mode_t     mode_q;
	logic [CW-1:0]   last_col_q;
	logic [XW-1:0]   width_x;
	logic [CW-1:0]   last_col_new;

	assign cfg_ready = 1'b1;

	always_comb begin
		width_x = XW'(cfg_data);
		if (cfg_data == '0) begin
			last_col_new = '0;
		end else if (width_x > XW'(MAX_WIDTH)) begin
			last_col_new = MAX_LAST;
		end else begin
			last_col_new = CW'(width_x - XW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_ENCODE;
			last_col_q <= RESET_LAST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MODE:  mode_q     <= coder_mode_t'(cfg_data[0]);
				CFG_WIDTH: last_col_q <= last_col_new;
				default:   ;
			endcase
		end
	end

	// Stage 0: position tracking and line store read.
	logic          valid_s1;
	logic          adv_s1;
	logic          accept;
	logic [CW-1:0] col_q;
	logic          first_row_q;
	logic [CW-1:0] col_cur;
	logic          first_row_cur;

	assign adv_s1   = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign accept   = in_valid && in_ready;

	assign col_cur       = frame_start ? '0 : col_q;
	assign first_row_cur = frame_start || first_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			first_row_q <= 1'b1;
		end else if (accept) begin
			if (col_cur >= last_col_q) begin
				col_q       <= '0;
				first_row_q <= 1'b0;
			end else begin
				col_q       <= col_cur + CW'(1);
				first_row_q <= first_row_cur;
			end
		end
	end

	// Stage 1 registers.
	logic [CW-1:0] addr_s1;
	logic          raw_s1;
	logic          fwd_s1;
	pixel_t        fwd_data_s1;
	field_t        red_s1;
	field_t        green_s1;
	field_t        blue_s1;
	pixel_t        upper_rd;
	pixel_t        upper_px;
	pixel_t        new_px;
	pixel_t        left_q;
	pixel_t        upper_left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1     <= col_cur;
			raw_s1      <= first_row_cur || (col_cur == '0);
			// Catch the write made in this same cycle by the item ahead.
			fwd_s1      <= adv_s1 && (addr_s1 == col_cur);
			fwd_data_s1 <= new_px;
			red_s1      <= in_red;
			green_s1    <= in_green;
			blue_s1     <= in_blue;
		end
	end

	mpc_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_store (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_cur),
		.rd_data (upper_rd),
		.wr_en   (adv_s1),
		.wr_addr (addr_s1),
		.wr_data (new_px)
	);

	assign upper_px = fwd_s1 ? fwd_data_s1 : upper_rd;

	// Stage 1 prediction, one unit per channel.
	pred_ctrl_t ctrl_s1;
	field_t     res_red;
	field_t     res_green;
	field_t     res_blue;

	assign ctrl_s1 = '{mode: mode_q, raw: raw_s1};

	mpc_chan_predictor u_pred_red (
		.ctrl            (ctrl_s1),
		.left_chan       (left_q[7:0]),
		.upper_chan      (upper_px[7:0]),
		.upper_left_chan (upper_left_q[7:0]),
		.in_value        (red_s1),
		.out_value       (res_red),
		.pixel_chan      (new_px[7:0])
	);

	mpc_chan_predictor u_pred_green (
		.ctrl            (ctrl_s1),
		.left_chan       (left_q[15:8]),
		.upper_chan      (upper_px[15:8]),
		.upper_left_chan (upper_left_q[15:8]),
		.in_value        (green_s1),
		.out_value       (res_green),
		.pixel_chan      (new_px[15:8])
	);

	mpc_chan_predictor u_pred_blue (
		.ctrl            (ctrl_s1),
		.left_chan       (left_q[23:16]),
		.upper_chan      (upper_px[23:16]),
		.upper_left_chan (upper_left_q[23:16]),
		.in_value        (blue_s1),
		.out_value       (res_blue),
		.pixel_chan      (new_px[23:16])
	);

	// Advance the neighbor registers as each item leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			upper_left_q <= '0;
		end else if (adv_s1) begin
			left_q       <= new_px;
			upper_left_q <= upper_px;
		end
	end

	// Output register: hold while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_red   <= res_red;
			out_green <= res_green;
			out_blue  <= res_blue;
			is_raw    <= raw_s1;
		end
	end

	// Checks.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= MAX_LAST)
		else $error("column counter beyond line store depth");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted item lost before stage 1");

	a_frame_start_raw: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_start |=> raw_s1)
		else $error("first pixel of a frame not marked raw");

	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while stage 1 is blocked");

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import mpc_pkg::*;

	localparam int LINE_MAX = 4096;

	// One pixel item as offered on the input channel.
	typedef struct packed {
		logic   fs;
		field_t red;
		field_t green;
		field_t blue;
	} px_item_t;

	// One coded pixel as expected on the output channel.
	typedef struct packed {
		field_t red;
		field_t green;
		field_t blue;
		logic   raw;
	} coded_px_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_MODE;
	logic [12:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        frame_start = 1'b0;
	field_t      in_red = '0;
	field_t      in_green = '0;
	field_t      in_blue = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic signed [8:0] out_red;
	logic signed [8:0] out_green;
	logic signed [8:0] out_blue;
	logic        is_raw;

	// Items waiting to be offered, and coded pixels waiting to come out.
	px_item_t  pending_pixels[$];
	coded_px_t coded_due[$];

	// Shadow of the configuration registers.
	coder_mode_t cur_mode = MODE_ENCODE;
	logic [12:0] cur_width = 13'd4096;

	// Shadow of the coder's neighbor state.
	pixel_t line_mem [0:LINE_MAX-1];
	pixel_t left_px = '0;
	pixel_t upleft_px = '0;
	int     col_pos = 0;
	logic   top_row = 1'b1;

	logic in_took = 1'b0;
	int   burst_left = 0;
	int   gap_left = 0;
	int   hold_left = 0;
	int   stretch_left = 0;
	int   stretch_kind = 0;
	logic long_hold_done = 1'b0;
	int   pixels_checked = 0;
	int   mismatches = 0;

	med_predictive_pixel_coder DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.frame_start (frame_start),
		.in_red      (in_red),
		.in_green    (in_green),
		.in_blue     (in_blue),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.is_raw      (is_raw)
	);

	always #5 clk = ~clk;

	// Median edge detector on one channel: left a, upper b, upper-left c.
	function automatic chan_t edge_median(input chan_t a, input chan_t b, input chan_t c);
		chan_t small_v;
		chan_t big_v;
		small_v = a;
		big_v   = b;
		if (b < a) begin
			small_v = b;
			big_v   = a;
		end
		if (c >= big_v) begin
			return small_v;
		end
		if (c <= small_v) begin
			return big_v;
		end
		return chan_t'(a + b - c);
	endfunction

	// Code one accepted pixel item and queue the coded pixel it must produce.
	task automatic code_pixel(input logic fs, input field_t r, input field_t g, input field_t b);
		field_t    fld [3];
		field_t    res [3];
		pixel_t    upper;
		pixel_t    merged;
		chan_t     pred;
		chan_t     pix;
		logic      raw;
		int        row_len;
		coded_px_t got;
		fld[0] = r;
		fld[1] = g;
		fld[2] = b;
		// A frame start restarts the position at the top-left corner.
		if (fs) begin
			col_pos = 0;
			top_row = 1'b1;
		end
		// Clamp the row length: zero acts as one, above the store size saturates.
		row_len = (cur_width == 0) ? 1 : int'(cur_width);
		if (row_len > LINE_MAX) begin
			row_len = LINE_MAX;
		end
		if (col_pos >= LINE_MAX) begin
			col_pos = LINE_MAX - 1;
		end
		raw    = top_row || (col_pos == 0);
		upper  = line_mem[col_pos];
		merged = '0;
		for (int k = 0; k < NUM_CHAN; k++) begin
			pred = raw ? chan_t'(0) :
				edge_median(left_px[k*CHAN_W +: CHAN_W], upper[k*CHAN_W +: CHAN_W],
					upleft_px[k*CHAN_W +: CHAN_W]);
			if (cur_mode == MODE_ENCODE) begin
				// Only the low byte of an encode input counts as the pixel.
				pix    = fld[k][7:0];
				res[k] = raw ? {1'b0, pix} : ({1'b0, pix} - {1'b0, pred});
			end else begin
				pix    = raw ? fld[k][7:0] : chan_t'(fld[k][7:0] + pred);
				res[k] = {1'b0, pix};
			end
			merged[k*CHAN_W +: CHAN_W] = pix;
		end
		line_mem[col_pos] = merged;
		upleft_px = upper;
		left_px   = merged;
		// Advance the column; wrap at the row end and leave the first row.
		if (col_pos + 1 >= row_len) begin
			col_pos = 0;
			top_row = 1'b0;
		end else begin
			col_pos = col_pos + 1;
		end
		got.red   = res[0];
		got.green = res[1];
		got.blue  = res[2];
		got.raw   = raw;
		coded_due.push_back(got);
	endtask

	// Predict on input accepts and check output accepts, both sampled at the rising edge.
	always @(posedge clk) begin
		coded_px_t want;
		in_took <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			code_pixel(frame_start, in_red, in_green, in_blue);
		end
		if (arst_n && out_valid && out_ready) begin
			pixels_checked <= pixels_checked + 1;
			if (coded_due.size() == 0) begin
				$error("coded pixel with none expected: %0d %0d %0d raw %0b",
					out_red, out_green, out_blue, is_raw);
				mismatches++;
			end else begin
				want = coded_due.pop_front();
				if (out_red !== want.red) begin
					$error("out_red expected %0d got %0d", $signed(want.red), out_red);
					mismatches++;
				end
				if (out_green !== want.green) begin
					$error("out_green expected %0d got %0d", $signed(want.green), out_green);
					mismatches++;
				end
				if (out_blue !== want.blue) begin
					$error("out_blue expected %0d got %0d", $signed(want.blue), out_blue);
					mismatches++;
				end
				if (is_raw !== want.raw) begin
					$error("is_raw expected %0b got %0b", want.raw, is_raw);
					mismatches++;
				end
			end
		end
	end

	// Sender: hold an offered item until taken, then feed the next one in bursts with gaps.
	always @(negedge clk) begin
		px_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_took) begin
			// hold the item and its payload
		end else if (gap_left != 0) begin
			in_valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending_pixels.size() != 0) begin
			nxt = pending_pixels.pop_front();
			in_valid    <= 1'b1;
			frame_start <= nxt.fs;
			in_red      <= nxt.red;
			in_green    <= nxt.green;
			in_blue     <= nxt.blue;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 48);
				gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver: stretches of steady, patchy or mostly stalled ready, plus one long hold-off
	// that lets the coder fill up and push back on its input.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!long_hold_done && pixels_checked >= 300) begin
			out_ready      <= 1'b0;
			hold_left      <= 120;
			long_hold_done <= 1'b1;
		end else begin
			if (stretch_left == 0) begin
				stretch_left <= $urandom_range(4, 40);
				stretch_kind <= $urandom_range(0, 3);
			end else begin
				stretch_left <= stretch_left - 1;
			end
			case (stretch_kind)
				0: begin
					out_ready <= 1'b1;
				end
				1: begin
					out_ready <= ($urandom_range(0, 3) != 0);
				end
				2: begin
					out_ready <= ($urandom_range(0, 1) == 1);
				end
				default: begin
					out_ready <= ($urandom_range(0, 3) == 0);
				end
			endcase
		end
	end

	task automatic push_pixel(input logic fs, input field_t r, input field_t g, input field_t b);
		px_item_t item;
		item.fs    = fs;
		item.red   = r;
		item.green = g;
		item.blue  = b;
		pending_pixels.push_back(item);
	endtask

	// Write one register at the falling edge and hold until it is taken.
	task automatic write_reg(input logic idx, input logic [12:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_MODE) begin
			cur_mode = coder_mode_t'(val[0]);
		end else begin
			cur_width = val;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drain: nothing left to offer, nothing in flight, then let the pipeline settle.
	task automatic wait_idle();
		do @(negedge clk); while (pending_pixels.size() != 0 || in_valid || coded_due.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	// Encode inputs are mostly true pixels; residuals and stray encode inputs span -255..255.
	function automatic field_t rand_field(input coder_mode_t m);
		if (m == MODE_ENCODE && $urandom_range(0, 9) != 0) begin
			return field_t'($urandom_range(0, 255));
		end
		return field_t'($urandom_range(0, 510) - 255);
	endfunction

	// Run a stream of frames at one setting: a frame start opens it, a few restart mid-frame.
	task automatic run_frames(input coder_mode_t m, input logic [12:0] w, input int n);
		write_reg(CFG_MODE, {12'($urandom_range(0, 4095)), m});
		write_reg(CFG_WIDTH, w);
		for (int i = 0; i < n; i++) begin
			push_pixel((i == 0) || ($urandom_range(0, 49) == 0),
				rand_field(m), rand_field(m), rand_field(m));
		end
		wait_idle();
	endtask

	initial begin
		int           random_count;
		int           n;
		logic [12:0]  w;
		random_count = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset setting: encode, full-length row, so everything here is raw.
		// The last pixel is out of range and keeps only its low byte.
		push_pixel(1'b1, 0, 0, 0);
		push_pixel(1'b0, 255, 255, 255);
		push_pixel(1'b0, -255, -1, 128);
		wait_idle();

		// Encode a 3-wide image chosen to hit every median branch and both residual extremes,
		// then restart the frame mid-row.
		write_reg(CFG_MODE, 13'h1FFE);
		write_reg(CFG_WIDTH, 13'd3);
		push_pixel(1'b1, 200, 10, 100);
		push_pixel(1'b0, 50, 200, 150);
		push_pixel(1'b0, 0, 0, 0);
		push_pixel(1'b0, 100, 100, 50);
		push_pixel(1'b0, 0, 255, 100);
		push_pixel(1'b0, 255, 0, 255);
		push_pixel(1'b0, 255, 255, 255);
		push_pixel(1'b0, 0, 0, 0);
		push_pixel(1'b1, 17, 34, 51);
		push_pixel(1'b0, -1, -128, -200);
		wait_idle();

		// Decode with width zero: every pixel is its own row, so all raw.
		write_reg(CFG_MODE, 13'h0001);
		write_reg(CFG_WIDTH, 13'd0);
		push_pixel(1'b1, -255, 255, 0);
		push_pixel(1'b0, 255, -255, -1);
		push_pixel(1'b0, 1, 128, -128);
		wait_idle();

		// Decode a 2-wide image with extreme residuals so sums wrap.
		write_reg(CFG_WIDTH, 13'd2);
		push_pixel(1'b1, 0, 255, 128);
		push_pixel(1'b0, 255, 0, 1);
		push_pixel(1'b0, -255, 255, -1);
		push_pixel(1'b0, 255, -255, 255);
		push_pixel(1'b0, 0, 1, -255);
		push_pixel(1'b0, -255, -255, 255);
		wait_idle();

		// Random streams: mostly short rows so many rows get predicted.
		while (random_count < 800) begin
			n = $urandom_range(20, 120);
			case ($urandom_range(0, 9))
				0: w = 13'd0;
				1: w = 13'd1;
				2: w = 13'd2;
				3: w = 13'd3;
				4, 5, 6: w = 13'($urandom_range(4, 16));
				default: w = 13'($urandom_range(17, 64));
			endcase
			run_frames(coder_mode_t'($urandom_range(0, 1)), w, n);
			random_count += n;
		end

		// Largest width written as all ones: saturates to the store size, so the
		// whole short stream stays in the first row.
		run_frames(coder_mode_t'($urandom_range(0, 1)), 13'h1FFF, 40);

		if (mismatches == 0 && coded_due.size() == 0) begin
			$display("[med_predictive_pixel_coder] OK");
		end else begin
			$display("[med_predictive_pixel_coder] ERROR");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("[med_predictive_pixel_coder] ERROR");
		$finish;
	end

endmodule
